/* rtl/flvp_pkg.sv */
package flvp_pkg;

    localparam int GOP_DEPTH = 256;
    localparam int GOP_AW    = $clog2(GOP_DEPTH);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [3:0]  FILE_HEAD_LEN = 4'd13;
    localparam logic [3:0]  TAG_HEAD_LEN  = 4'd11;
    localparam logic [3:0]  FLAGS_POS     = 4'd4;
    localparam logic [24:0] TRAILER_LEN   = 25'd4;
    localparam logic [7:0]  FLAGS_AV      = 8'h05;
    localparam logic [7:0]  AVC_SEQ_BYTE  = 8'd23;
    localparam logic [7:0]  TYPE_AUDIO    = 8'd8;
    localparam logic [7:0]  TYPE_VIDEO    = 8'd9;
    localparam logic [7:0]  TYPE_SCRIPT   = 8'd18;
    localparam logic [3:0]  FMT_AAC       = 4'd10;
    localparam logic [3:0]  FRAME_KEY     = 4'd1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_TAG    = 1'b1;

    localparam int OUT_DATA_W = 64;

    // framed event handed from the byte parser to the tag logic
    typedef struct packed {
        logic        kind;
        logic        flags_av;
        logic [7:0]  tag_type;
        logic [23:0] size;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
    } evt_t;

    typedef struct packed {
        logic push;
        evt_t evt;
    } evt_push_t;

    typedef struct packed {
        logic full;
        logic valid;
        evt_t evt;
    } evt_q_stat_t;

endpackage

/* rtl/flvp_front.sv */
module flvp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    output flvp_pkg::evt_push_t push
);
    import flvp_pkg::*;

    typedef enum logic [2:0] {
        PH_FILE = 3'b001,
        PH_TAG  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [3:0]   pos_reg, pos_next;
    logic [7:0]   flags_reg, flags_next;
    logic [7:0]   type_reg, type_next;
    logic [23:0]  size_reg, size_next;
    logic [24:0]  rem_reg, rem_next;
    logic [1:0]   ppos_reg, ppos_next;
    logic [7:0]   first_reg, first_next;
    logic [7:0]   second_reg, second_next;
    logic [24:0]  rem_dec;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        type_next   = type_reg;
        size_next   = size_reg;
        rem_next    = rem_reg;
        ppos_next   = ppos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        push        = '0;
        rem_dec     = (rem_reg != '0) ? rem_reg - 25'd1 : rem_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FILE:
                begin
                    if (pos_reg == FLAGS_POS)
                    begin
                        flags_next = data_byte;
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == FILE_HEAD_LEN - 4'd1)
                    begin
                        pos_next            = '0;
                        phase_next          = PH_TAG;
                        push.push           = 1'b1;
                        push.evt.kind       = KIND_HEADER;
                        push.evt.flags_av   = (flags_reg == FLAGS_AV);
                    end
                end
                PH_TAG:
                begin
                    if (pos_reg == 4'd0)
                    begin
                        type_next = data_byte;
                        size_next = '0;
                    end
                    else if (pos_reg <= 4'd3)
                    begin
                        size_next = {size_reg[15:0], data_byte};
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == TAG_HEAD_LEN - 4'd1)
                    begin
                        pos_next    = '0;
                        rem_next    = {1'b0, size_reg} + TRAILER_LEN;
                        ppos_next   = '0;
                        first_next  = '0;
                        second_next = '0;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (ppos_reg == 2'd0)
                    begin
                        first_next = data_byte;
                        ppos_next  = 2'd1;
                    end
                    else if (ppos_reg == 2'd1)
                    begin
                        second_next = data_byte;
                        ppos_next   = 2'd2;
                    end
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next           = PH_TAG;
                        push.push            = 1'b1;
                        push.evt.kind        = KIND_TAG;
                        push.evt.tag_type    = type_reg;
                        push.evt.size        = size_reg;
                        push.evt.first_byte  = first_next;
                        push.evt.second_byte = second_next;
                    end
                end
                default:
                begin
                    phase_next = PH_FILE;
                    pos_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FILE;
            pos_reg    <= '0;
            flags_reg  <= '0;
            type_reg   <= '0;
            size_reg   <= '0;
            rem_reg    <= '0;
            ppos_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
            type_reg   <= type_next;
            size_reg   <= size_next;
            rem_reg    <= rem_next;
            ppos_reg   <= ppos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

/* rtl/flvp_queue.sv */
module flvp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  flvp_pkg::evt_push_t    push,
    input  logic                   pop,
    output flvp_pkg::evt_q_stat_t  stat
);
    import flvp_pkg::*;

    evt_t              mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign stat.full  = (cnt_reg == Q_CW'(Q_DEPTH));
    assign stat.valid = (cnt_reg != '0);
    assign stat.evt   = mem_reg[rd_ptr_reg];

    assign do_push = push.push && !stat.full;
    assign do_pop  = pop && stat.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/flvp_back.sv */
module flvp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flush_count_we,
    input  logic [15:0]                   flush_count_wdata,
    input  flvp_pkg::evt_q_stat_t         q,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output logic [flvp_pkg::OUT_DATA_W-1:0] out_data
);
    import flvp_pkg::*;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    localparam logic [GOP_AW-1:0] GOP_LAST = GOP_AW'(GOP_DEPTH - 1);

    logic [15:0]        flush_count_reg;
    logic [15:0]        tsf_reg, tsf_next;
    logic [15:0]        fc_reg, fc_next;
    logic [GOP_AW-1:0]  gop_reg, gop_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] res_data;

    logic [3:0]         hi;
    logic               key_type, flush, aconf, vconf, key, script;
    logic [15:0]        tsf_inc;
    logic [GOP_AW-1:0]  slot;
    evt_t               e;

    assign e   = q.evt;
    assign pop = q.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        hi       = e.first_byte[7:4];
        key_type = (e.tag_type == TYPE_VIDEO) && (hi == FRAME_KEY);
        tsf_inc  = sat_inc16(tsf_reg);
        flush    = (tsf_inc == flush_count_reg) || key_type;
        aconf    = (e.tag_type == TYPE_AUDIO) && (hi == FMT_AAC) && (e.second_byte == '0);
        vconf    = (e.tag_type == TYPE_VIDEO) && (e.first_byte == AVC_SEQ_BYTE)
                   && (e.second_byte == '0);
        script   = (e.tag_type == TYPE_SCRIPT);
        key      = 1'b0;
        slot     = '0;
        tsf_next = flush ? '0 : tsf_inc;
        fc_next  = flush ? '0 : fc_reg;
        gop_next = gop_reg;
        if ((e.tag_type == TYPE_VIDEO) && !vconf)
        begin
            if (hi == FRAME_KEY)
            begin
                key  = 1'b1;
                slot = '0;
            end
            else
            begin
                slot = gop_reg;
                if (tsf_next != '0)
                begin
                    fc_next = sat_inc16(fc_next);
                end
            end
            gop_next = (slot < GOP_LAST) ? slot + 1'b1 : slot;
        end

        res_data = '0;
        if (e.kind == KIND_HEADER)
        begin
            res_data[0] = e.flags_av;
        end
        else
        begin
            res_data[8:1]   = e.tag_type;
            res_data[32:9]  = e.size;
            res_data[33]    = aconf;
            res_data[34]    = vconf;
            res_data[35]    = key;
            res_data[36]    = flush;
            res_data[44:37] = 8'(slot);
            res_data[60:45] = fc_next;
            res_data[61]    = script;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_kind_reg <= e.kind;
            out_data_reg <= res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_count_reg <= '0;
            tsf_reg         <= '0;
            fc_reg          <= '0;
            gop_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (flush_count_we)
            begin
                flush_count_reg <= flush_count_wdata;
            end
            if (pop && (e.kind == KIND_TAG))
            begin
                tsf_reg <= tsf_next;
                fc_reg  <= fc_next;
                gop_reg <= gop_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/flv_tag_stream_parser_unit.sv */
// FLV tag stream parser.
// Throughput: one byte and up to one header or tag result per cycle, while not stalled.
// A result enters the event queue with its last byte, then the m_axis output register.
// s_axis_tready drops only when the two-entry event queue fills behind a stalled m_axis.
// Reset (rst_n low, asynchronous): parser at start of file header, counters, GOP slot
// and flush_count cleared, queue and output register empty.
module flv_tag_stream_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] stream_flags_av, [8:1] tag_type, [32:9] payload_size, [33] is_audio_config,
    // [34] is_video_config, [35] is_keyframe, [36] flush_now, [44:37] gop_slot,
    // [60:45] frames_since_flush, [61] is_script, [63:62] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] result_kind
    input  logic        flush_count_we,
    input  logic [15:0] flush_count_wdata
);
    import flvp_pkg::*;

    evt_push_t   push;
    evt_q_stat_t q_stat;
    logic        pop;
    logic        s_accept;

    assign s_axis_tready = !q_stat.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    flvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_accept),
        .data_byte (s_axis_tdata),
        .push      (push)
    );

    flvp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .stat  (q_stat)
    );

    flvp_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .flush_count_we    (flush_count_we),
        .flush_count_wdata (flush_count_wdata),
        .q                 (q_stat),
        .pop               (pop),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_kind          (m_axis_tuser),
        .out_data          (m_axis_tdata)
    );

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_HEADER)) |-> (m_axis_tdata[63:1] == '0))
        else $error("header result carries tag fields");

    a_key_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[35]) |-> m_axis_tdata[36])
        else $error("keyframe without flush");

    a_flush_frames: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[36]) |-> (m_axis_tdata[60:45] == '0))
        else $error("frame count not cleared on flush");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && push.push) |-> !s_accept)
        else $error("event pushed into full queue");

endmodule
